/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
// each macro expands to a concurrent assertion in simulation and to nothing in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define TCCE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tcce assertion failed");
// condition must never be true outside reset
`define TCCE_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tcce forbidden condition seen");
`else
`define TCCE_ASSERT(label, clk, rst_n, prop)
`define TCCE_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* hw/rtl/tcce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Types, constants and helpers shared by the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // sizes
    localparam int COORD_BITS   = 12;
    localparam int SUM_BITS     = COORD_BITS + 1;
    localparam int STACK_DEPTH  = 256;
    localparam int STACK_AW     = $clog2(STACK_DEPTH);
    localparam int CNT_BITS     = $clog2(STACK_DEPTH + 1);
    localparam int CODE_BITS    = 21;
    localparam int DIM_BITS     = 8;
    localparam int ADV_BITS     = DIM_BITS + 2;
    localparam int AMT_BITS     = DIM_BITS + 3;
    localparam int DIV_CNT_BITS = $clog2(COORD_BITS + 1);
    localparam int PADDR_BITS   = 5;
    localparam int PDATA_BITS   = 32;

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    // control characters
    localparam logic [CODE_BITS-1:0] CHAR_NUL = 21'h00;
    localparam logic [CODE_BITS-1:0] CHAR_BS  = 21'h08;
    localparam logic [CODE_BITS-1:0] CHAR_TAB = 21'h09;
    localparam logic [CODE_BITS-1:0] CHAR_LF  = 21'h0A;
    localparam logic [CODE_BITS-1:0] CHAR_CR  = 21'h0D;

    // register reset values
    localparam logic [COORD_BITS-1:0] RST_WIN_MIN_X   = 12'd48;
    localparam logic [COORD_BITS-1:0] RST_WIN_MIN_Y   = 12'd48;
    localparam logic [COORD_BITS-1:0] RST_WIN_MAX_X   = 12'd592;
    localparam logic [COORD_BITS-1:0] RST_WIN_MAX_Y   = 12'd432;
    localparam logic [DIM_BITS-1:0]   RST_LINE_HEIGHT = 8'd16;
    localparam logic [DIM_BITS-1:0]   RST_SPACE_WIDTH = 8'd8;

    typedef enum logic [1:0] {
        KIND_SCROLL = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_DRAW   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_WIN_MIN_X   = 3'd0,
        REG_WIN_MIN_Y   = 3'd1,
        REG_WIN_MAX_X   = 3'd2,
        REG_WIN_MAX_Y   = 3'd3,
        REG_LINE_HEIGHT = 3'd4,
        REG_SPACE_WIDTH = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_NUL,
        OP_LF,
        OP_CR,
        OP_TAB,
        OP_BS,
        OP_GLYPH
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_NL_SCROLL,
        ST_NL_STEP,
        ST_TAB_DIV,
        ST_TAB_WAIT,
        ST_PUSH,
        ST_EMIT,
        ST_BS_EMIT
    } state_t;

    typedef logic [SUM_BITS-1:0] sum_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] char_code;
        logic [DIM_BITS-1:0]  glyph_width;
    } in_word_t;

    typedef struct packed {
        kind_t                 kind;
        logic [COORD_BITS-1:0] rect_x0;
        logic [COORD_BITS-1:0] rect_y0;
        logic [COORD_BITS-1:0] rect_x1;
        logic [COORD_BITS-1:0] rect_y1;
        logic [AMT_BITS-1:0]   scroll_amount;
        logic [CODE_BITS-1:0]  glyph_code;
        logic                  last;
    } out_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] win_min_x;
        logic [COORD_BITS-1:0] win_min_y;
        logic [COORD_BITS-1:0] win_max_x;
        logic [COORD_BITS-1:0] win_max_y;
        logic [DIM_BITS-1:0]   line_height;
        logic [DIM_BITS-1:0]   space_width;
    } cfg_t;

    // saturate a one-bit-grown sum back into coordinate range
    function automatic logic [COORD_BITS-1:0] sat_coord(input sum_t v);
        return v[COORD_BITS] ? COORD_MAX : v[COORD_BITS-1:0];
    endfunction

endpackage

/* hw/rtl/tcce_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_div
// Restoring divider, one quotient bit per cycle, for the tab column.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcce_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [tcce_pkg::COORD_BITS-1:0]     dividend,
    input  logic [tcce_pkg::DIM_BITS-1:0]       divisor,
    output logic                                busy,
    output logic                                done,
    output logic [tcce_pkg::COORD_BITS-1:0]     quotient
);

    logic                                   busy_reg, busy_next;
    logic                                   done_reg, done_next;
    logic [tcce_pkg::DIV_CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [tcce_pkg::DIM_BITS-1:0]          rem_reg, rem_next;
    logic [tcce_pkg::DIM_BITS-1:0]          dvs_reg, dvs_next;
    logic [tcce_pkg::COORD_BITS-1:0]        quo_reg, quo_next;
    logic [tcce_pkg::DIM_BITS:0]            trial;
    logic                                   fits;

    // one shift-subtract step
    always_comb
    begin
        trial = {rem_reg, quo_reg[tcce_pkg::COORD_BITS-1]};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // iteration control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = tcce_pkg::DIV_CNT_BITS'(tcce_pkg::COORD_BITS);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? tcce_pkg::DIM_BITS'(trial - {1'b0, dvs_reg})
                            : trial[tcce_pkg::DIM_BITS-1:0];
            quo_next = {quo_reg[tcce_pkg::COORD_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tcce_pkg::DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    `TCCE_ASSERT(a_div_start_idle, clk, rst_n, start |-> !busy_reg)
    `TCCE_ASSERT(a_div_start_runs, clk, rst_n, start |=> busy_reg)
    `TCCE_ASSERT_NEVER(a_div_cnt_live, clk, rst_n,
                       busy_reg && (cnt_reg == tcce_pkg::DIV_CNT_BITS'(0)))

endmodule

/* hw/rtl/tcce_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ctrl
// Cursor sequencer: decodes a character, walks newline, tab and backspace
// steps, keeps the back stack and hands drawing words to the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcce_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tcce_pkg::cfg_t          cfg,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  tcce_pkg::in_word_t      in_word,
    output logic                    emit_valid,
    input  logic                    emit_ready,
    output tcce_pkg::out_word_t     emit_word
);

    tcce_pkg::state_t                   state_reg, state_next;
    tcce_pkg::op_t                      op_reg, op_next, op_in;
    logic [tcce_pkg::CODE_BITS-1:0]     code_reg, code_next;
    logic [tcce_pkg::DIM_BITS-1:0]      gw_reg, gw_next;
    logic [tcce_pkg::COORD_BITS-1:0]    x_reg, x_next;
    logic [tcce_pkg::COORD_BITS-1:0]    y_reg, y_next;
    logic [tcce_pkg::CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [tcce_pkg::ADV_BITS-1:0]      adv_reg, adv_next;

    // back stack
    logic [tcce_pkg::COORD_BITS-1:0]    stack_mem [tcce_pkg::STACK_DEPTH];
    logic [tcce_pkg::COORD_BITS-1:0]    stk_rdata_reg;
    logic                               stk_we, stk_re;
    logic [tcce_pkg::CNT_BITS-1:0]      cnt_dec;

    // divider
    logic                               div_start, div_busy, div_done;
    logic [tcce_pkg::COORD_BITS-1:0]    div_quo;
    logic [tcce_pkg::COORD_BITS-1:0]    tab_off;

    // arithmetic helpers
    logic [tcce_pkg::DIM_BITS-1:0]      sp_w;
    logic [tcce_pkg::ADV_BITS-1:0]      sp_w4, tab_adv;
    logic [tcce_pkg::AMT_BITS-1:0]      scroll_amt;
    tcce_pkg::sum_t                     tab_sum, gl_sum, y_down, y_up, x_adv;
    logic                               tab_wrap, gl_wrap, scroll_need;

    // character class of an incoming word
    always_comb
    begin
        if (in_word.char_code == tcce_pkg::CHAR_NUL)
            op_in = tcce_pkg::OP_NUL;
        else if (in_word.char_code == tcce_pkg::CHAR_LF)
            op_in = tcce_pkg::OP_LF;
        else if (in_word.char_code == tcce_pkg::CHAR_CR)
            op_in = tcce_pkg::OP_CR;
        else if (in_word.char_code == tcce_pkg::CHAR_TAB)
            op_in = tcce_pkg::OP_TAB;
        else if (in_word.char_code == tcce_pkg::CHAR_BS)
            op_in = tcce_pkg::OP_BS;
        else
            op_in = tcce_pkg::OP_GLYPH;
    end

    // window and tab arithmetic
    always_comb
    begin
        sp_w        = (cfg.space_width == '0) ? tcce_pkg::DIM_BITS'(1) : cfg.space_width;
        sp_w4       = {sp_w, 2'b00};
        scroll_amt  = {cfg.line_height, 3'b000};
        tab_sum     = tcce_pkg::sum_t'(x_reg) + tcce_pkg::sum_t'(sp_w4);
        gl_sum      = tcce_pkg::sum_t'(x_reg) + tcce_pkg::sum_t'(gw_reg);
        tab_wrap    = (tab_sum >= tcce_pkg::sum_t'(cfg.win_max_x));
        gl_wrap     = (gl_sum >= tcce_pkg::sum_t'(cfg.win_max_x));
        y_down      = tcce_pkg::sum_t'(y_reg) + tcce_pkg::sum_t'(cfg.line_height);
        scroll_need = (y_down >= tcce_pkg::sum_t'(cfg.win_max_y));
        y_up        = tcce_pkg::sum_t'(y_reg) - tcce_pkg::sum_t'(scroll_amt);
        x_adv       = tcce_pkg::sum_t'(x_reg) + tcce_pkg::sum_t'(adv_reg);
        tab_off     = (x_reg >= cfg.win_min_x) ? (x_reg - cfg.win_min_x) : '0;
        cnt_dec     = cnt_reg - 1'b1;
        // distance to next stop: (4 - column mod 4) space widths
        case (div_quo[1:0])
            2'd0:    tab_adv = sp_w4;
            2'd1:    tab_adv = {1'b0, sp_w, 1'b0} + tcce_pkg::ADV_BITS'(sp_w);
            2'd2:    tab_adv = {1'b0, sp_w, 1'b0};
            default: tab_adv = tcce_pkg::ADV_BITS'(sp_w);
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcce_pkg::ST_IDLE:
                if (in_valid)
                    state_next = tcce_pkg::ST_DECODE;
            tcce_pkg::ST_DECODE:
                unique case (op_reg)
                    tcce_pkg::OP_LF:
                        state_next = tcce_pkg::ST_NL_SCROLL;
                    tcce_pkg::OP_TAB:
                        state_next = tab_wrap ? tcce_pkg::ST_NL_SCROLL : tcce_pkg::ST_TAB_DIV;
                    tcce_pkg::OP_BS:
                        state_next = (cnt_reg == '0) ? tcce_pkg::ST_IDLE : tcce_pkg::ST_BS_EMIT;
                    tcce_pkg::OP_GLYPH:
                        state_next = gl_wrap ? tcce_pkg::ST_NL_SCROLL : tcce_pkg::ST_PUSH;
                    default:
                        state_next = tcce_pkg::ST_IDLE;
                endcase
            tcce_pkg::ST_NL_SCROLL:
                if (!scroll_need || emit_ready)
                    state_next = tcce_pkg::ST_NL_STEP;
            tcce_pkg::ST_NL_STEP:
                unique case (op_reg)
                    tcce_pkg::OP_LF:  state_next = tcce_pkg::ST_IDLE;
                    tcce_pkg::OP_TAB: state_next = tcce_pkg::ST_TAB_DIV;
                    default:          state_next = tcce_pkg::ST_PUSH;
                endcase
            tcce_pkg::ST_TAB_DIV:
                state_next = tcce_pkg::ST_TAB_WAIT;
            tcce_pkg::ST_TAB_WAIT:
                if (div_done)
                    state_next = tcce_pkg::ST_PUSH;
            tcce_pkg::ST_PUSH:
                state_next = tcce_pkg::ST_EMIT;
            tcce_pkg::ST_EMIT,
            tcce_pkg::ST_BS_EMIT:
                if (emit_ready)
                    state_next = tcce_pkg::ST_IDLE;
            default:
                state_next = tcce_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs per state
    always_comb
    begin
        op_next    = op_reg;
        code_next  = code_reg;
        gw_next    = gw_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        adv_next   = adv_reg;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        div_start  = 1'b0;
        emit_valid = 1'b0;
        emit_word  = '0;
        unique case (state_reg)
            tcce_pkg::ST_IDLE:
                if (in_valid)
                begin
                    op_next   = op_in;
                    code_next = in_word.char_code;
                    gw_next   = in_word.glyph_width;
                    // a full stack forgets everything
                    if (cnt_reg == tcce_pkg::CNT_BITS'(tcce_pkg::STACK_DEPTH))
                        cnt_next = '0;
                end
            tcce_pkg::ST_DECODE:
                unique case (op_reg)
                    tcce_pkg::OP_CR:
                    begin
                        cnt_next = '0;
                        x_next   = cfg.win_min_x;
                    end
                    tcce_pkg::OP_BS:
                        if (cnt_reg != '0)
                        begin
                            cnt_next = cnt_dec;
                            stk_re   = 1'b1;
                        end
                    tcce_pkg::OP_GLYPH:
                        adv_next = tcce_pkg::ADV_BITS'(gw_reg);
                    default:
                        ;
                endcase
            tcce_pkg::ST_NL_SCROLL:
                if (scroll_need)
                begin
                    emit_valid              = 1'b1;
                    emit_word.kind          = tcce_pkg::KIND_SCROLL;
                    emit_word.rect_x0       = cfg.win_min_x;
                    emit_word.rect_y0       = cfg.win_min_y;
                    emit_word.rect_x1       = cfg.win_max_x;
                    emit_word.rect_y1       = cfg.win_max_y;
                    emit_word.scroll_amount = scroll_amt;
                    emit_word.last          = (op_reg == tcce_pkg::OP_LF);
                    // scrolling past the top clamps at zero
                    if (emit_ready)
                        y_next = y_up[tcce_pkg::COORD_BITS] ? '0
                                 : y_up[tcce_pkg::COORD_BITS-1:0];
                end
            tcce_pkg::ST_NL_STEP:
            begin
                y_next   = tcce_pkg::sat_coord(y_down);
                cnt_next = '0;
                x_next   = cfg.win_min_x;
            end
            tcce_pkg::ST_TAB_DIV:
                div_start = 1'b1;
            tcce_pkg::ST_TAB_WAIT:
                if (div_done)
                    adv_next = tab_adv;
            tcce_pkg::ST_PUSH:
            begin
                stk_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            tcce_pkg::ST_EMIT:
            begin
                emit_valid        = 1'b1;
                emit_word.kind    = (op_reg == tcce_pkg::OP_TAB) ? tcce_pkg::KIND_CLEAR
                                                                 : tcce_pkg::KIND_DRAW;
                emit_word.rect_x0 = x_reg;
                emit_word.rect_y0 = y_reg;
                emit_word.rect_x1 = tcce_pkg::sat_coord(x_adv);
                emit_word.rect_y1 = tcce_pkg::sat_coord(y_down);
                emit_word.glyph_code = (op_reg == tcce_pkg::OP_GLYPH) ? code_reg : '0;
                emit_word.last    = 1'b1;
                if (emit_ready)
                    x_next = tcce_pkg::sat_coord(x_adv);
            end
            tcce_pkg::ST_BS_EMIT:
            begin
                emit_valid        = 1'b1;
                emit_word.kind    = tcce_pkg::KIND_CLEAR;
                emit_word.rect_x0 = stk_rdata_reg;
                emit_word.rect_y0 = y_reg;
                emit_word.rect_x1 = x_reg;
                emit_word.rect_y1 = tcce_pkg::sat_coord(y_down);
                emit_word.last    = 1'b1;
                if (emit_ready)
                    x_next = stk_rdata_reg;
            end
            default:
                ;
        endcase
    end

    assign in_stall = (state_reg != tcce_pkg::ST_IDLE);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcce_pkg::ST_IDLE;
            op_reg    <= tcce_pkg::OP_NUL;
            x_reg     <= tcce_pkg::RST_WIN_MIN_X;
            y_reg     <= tcce_pkg::RST_WIN_MIN_Y;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload holding registers
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        gw_reg   <= gw_next;
        adv_reg  <= adv_next;
    end

    // back stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[cnt_reg[tcce_pkg::STACK_AW-1:0]] <= x_reg;
        if (stk_re)
            stk_rdata_reg <= stack_mem[cnt_dec[tcce_pkg::STACK_AW-1:0]];
    end

    // tab column divider
    tcce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tab_off),
        .divisor  (sp_w),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    `TCCE_ASSERT(a_cnt_bound, clk, rst_n,
                 cnt_reg <= tcce_pkg::CNT_BITS'(tcce_pkg::STACK_DEPTH))
    `TCCE_ASSERT(a_last_ends_item, clk, rst_n,
                 (emit_valid && emit_ready && emit_word.last)
                 |=> (state_reg == tcce_pkg::ST_IDLE || state_reg == tcce_pkg::ST_NL_STEP))
    `TCCE_ASSERT(a_tab_wait_div, clk, rst_n,
                 (state_reg == tcce_pkg::ST_TAB_WAIT) |-> (div_busy || div_done))

endmodule

/* hw/rtl/text_console_cursor_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Text console cursor engine: character words in, drawing command words out.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_stall / in_word (char_code, glyph_width).
//                 in_stall stays high while a character is being worked on.
//   out channel : out_valid / out_stall / out_word. Each character gives zero,
//                 one or two words; the final one carries last.
//   apb port    : window edges, line height and space width at 4*index;
//                 write only while the engine is idle.
//   Sequencing: a wrap adds the newline steps (scroll, then step). A tab also
//   runs the bit-serial column divider, one bit a cycle over the 12-bit column
//   offset, to find its distance to the next tab stop.
//   Output register: a finished word sits in the out register; the sequencer
//   waits while out_stall holds it, and resumes as soon as it is taken.
//   Reset: registers return to their reset values, cursor to the window's top
//   left corner, back stack empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_cursor_engine_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // apb configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcce_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [tcce_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [tcce_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready,
    // character words
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tcce_pkg::in_word_t                  in_word,
    // drawing command words
    output logic                                out_valid,
    input  logic                                out_stall,
    output tcce_pkg::out_word_t                 out_word
);

    tcce_pkg::cfg_t             cfg_reg, cfg_next;
    tcce_pkg::reg_idx_t         reg_idx;
    logic                       cfg_wr;
    logic                       emit_valid, emit_ready;
    tcce_pkg::out_word_t        emit_word;
    logic                       out_valid_reg, out_valid_next;
    tcce_pkg::out_word_t        out_word_reg, out_word_next;

    // register decode
    assign reg_idx = tcce_pkg::reg_idx_t'(paddr[tcce_pkg::PADDR_BITS-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                tcce_pkg::REG_WIN_MIN_X:
                    cfg_next.win_min_x = pwdata[tcce_pkg::COORD_BITS-1:0];
                tcce_pkg::REG_WIN_MIN_Y:
                    cfg_next.win_min_y = pwdata[tcce_pkg::COORD_BITS-1:0];
                tcce_pkg::REG_WIN_MAX_X:
                    cfg_next.win_max_x = pwdata[tcce_pkg::COORD_BITS-1:0];
                tcce_pkg::REG_WIN_MAX_Y:
                    cfg_next.win_max_y = pwdata[tcce_pkg::COORD_BITS-1:0];
                tcce_pkg::REG_LINE_HEIGHT:
                    cfg_next.line_height = pwdata[tcce_pkg::DIM_BITS-1:0];
                tcce_pkg::REG_SPACE_WIDTH:
                    cfg_next.space_width = pwdata[tcce_pkg::DIM_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (reg_idx)
            tcce_pkg::REG_WIN_MIN_X:
                prdata = tcce_pkg::PDATA_BITS'(cfg_reg.win_min_x);
            tcce_pkg::REG_WIN_MIN_Y:
                prdata = tcce_pkg::PDATA_BITS'(cfg_reg.win_min_y);
            tcce_pkg::REG_WIN_MAX_X:
                prdata = tcce_pkg::PDATA_BITS'(cfg_reg.win_max_x);
            tcce_pkg::REG_WIN_MAX_Y:
                prdata = tcce_pkg::PDATA_BITS'(cfg_reg.win_max_y);
            tcce_pkg::REG_LINE_HEIGHT:
                prdata = tcce_pkg::PDATA_BITS'(cfg_reg.line_height);
            tcce_pkg::REG_SPACE_WIDTH:
                prdata = tcce_pkg::PDATA_BITS'(cfg_reg.space_width);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_min_x   <= tcce_pkg::RST_WIN_MIN_X;
            cfg_reg.win_min_y   <= tcce_pkg::RST_WIN_MIN_Y;
            cfg_reg.win_max_x   <= tcce_pkg::RST_WIN_MAX_X;
            cfg_reg.win_max_y   <= tcce_pkg::RST_WIN_MAX_Y;
            cfg_reg.line_height <= tcce_pkg::RST_LINE_HEIGHT;
            cfg_reg.space_width <= tcce_pkg::RST_SPACE_WIDTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // cursor sequencer
    tcce_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_word  (emit_word)
    );

    // output register
    assign emit_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (emit_valid && emit_ready)
        begin
            out_valid_next = 1'b1;
            out_word_next  = emit_word;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `TCCE_ASSERT(a_held_word_blocks, clk, rst_n,
                 (out_valid_reg && out_stall) |-> !emit_ready)
    `TCCE_ASSERT(a_emit_loads, clk, rst_n,
                 (emit_valid && emit_ready) |=> out_valid_reg)
    `TCCE_ASSERT_NEVER(a_no_accept_busy, clk, rst_n,
                       in_valid && !in_stall && emit_valid)

endmodule
